FILE: sv/dsep_pkg.sv
// Shared types, constants and calendar tables for the date string parser.
`default_nettype none
package dsep_pkg;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_D     = 8'd68;
  localparam logic [7:0] CH_J     = 8'd74;
  localparam logic [7:0] CH_M     = 8'd77;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  localparam int unsigned EPOCH_MJD      = 40587;
  localparam int unsigned MJD_LIMIT      = 24'hFFFFFF;
  localparam int unsigned SEC_PER_DAY    = 86400;
  localparam int unsigned DAYS_PER_ERA   = 146097;
  localparam int unsigned CIVIL_TO_EPOCH = 719468;
  localparam logic [40:0] EPOCH_MAX      = 41'd1446044745599;

  typedef enum logic [4:0] {
    PH_BLANK, PH_YEAR2ND, PH_YEARTAIL, PH_SEPMD, PH_MONTH2, PH_SEPD, PH_DAY2,
    PH_MJ, PH_MJD_D, PH_MJDSEP, PH_MJDDIG,
    PH_SEPH, PH_HOUR2, PH_SEPM, PH_MIN2, PH_SEPS, PH_SEC2, PH_DONE
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_beat_t;

  typedef struct packed {
    logic        status;
    logic [40:0] epoch_seconds;
    logic [6:0]  stop_index;
  } res_beat_t;

  typedef struct packed {
    logic        bad;
    logic        is_date;
    logic [4:0]  cent;
    logic [6:0]  yoc;
    logic [6:0]  mon;
    logic [6:0]  day;
    logic [23:0] dn;
    logic [6:0]  hr;
    logic [6:0]  mi;
    logic [6:0]  se;
    logic [6:0]  stop;
  } rec_t;

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // day offset of the first of each month in a March-based year
  function automatic logic [8:0] march_doy(logic [3:0] m);
    logic [8:0] ofs;
    case (m)
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage
`default_nettype wire

FILE: sv/dsep_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
`default_nettype none
interface dsep_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/date_string_to_epoch_seconds.sv
// Top level of the date string to Unix seconds parser.
//
// Channel  Dir  Payload                                      Beat
// char_i   in   char_code[7:0], last_char                    one character
// res_o    out  status, epoch_seconds[40:0], stop_index[6:0] one per string
//
// One character is taken every cycle while the queue is not full, and the parse state
// machine is registered per character. A string's result passes the queue entry, five calc
// stages and then the output register. The day-to-seconds multiply in the fifth stage
// sets the pipe depth.
// Reset clears the parse state, the two-entry queue and the pipe valids.
// An output stall holds the whole calc pipe; characters stall only when the queue is full.
`default_nettype none
module date_string_to_epoch_seconds #(
  parameter int MAX_STRING_LEN = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dsep_stream_if.sink   char_i,
  dsep_stream_if.source res_o
);
  import dsep_pkg::*;

  dsep_stream_if #(.T(rec_t)) fq_if ();
  dsep_stream_if #(.T(rec_t)) qb_if ();

  dsep_front #(
    .MAX_STRING_LEN(MAX_STRING_LEN)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .char_i(char_i),
    .rec_o (fq_if)
  );

  dsep_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_s  (fq_if),
    .out_s (qb_if)
  );

  dsep_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rec_i (qb_if),
    .res_o (res_o)
  );

endmodule
`default_nettype wire

FILE: sv/dsep_front.sv
// Character front end: per-character parse state machine, emits one record per string.
`default_nettype none
module dsep_front #(
  parameter int MAX_STRING_LEN = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dsep_stream_if.sink   char_i,
  dsep_stream_if.source rec_o
);
  import dsep_pkg::*;

  localparam int IDXW = $clog2(MAX_STRING_LEN + 1);

  typedef struct packed {
    phase_e            phase;
    logic [3:0]        fd;
    logic [23:0]       accum;
    logic [2:0]        cnt;
    logic [4:0]        cent;
    logic [6:0]        yoc;
    logic [6:0]        mon;
    logic [6:0]        day;
    logic [23:0]       dn;
    logic [6:0]        hr;
    logic [6:0]        mi;
    logic [6:0]        se;
    logic              is_date;
    logic [IDXW-1:0]   stop;
    logic              bad;
  } pst_t;

  localparam pst_t PST_RST = '{
    phase: PH_BLANK, fd: '0, accum: '0, cnt: '0, cent: '0, yoc: '0,
    mon: 7'd12, day: 7'd31, dn: '0, hr: 7'd23, mi: 7'd59, se: 7'd59,
    is_date: 1'b0, stop: '0, bad: 1'b0
  };

  localparam logic [4:0] CENT_19 = 5'd19;
  localparam logic [4:0] CENT_20 = 5'd20;

  function automatic pst_t take_char(pst_t s, logic [7:0] c, logic [IDXW-1:0] idx);
    pst_t        n;
    logic        dig;
    logic        blank;
    logic [3:0]  d;
    logic [6:0]  two;
    logic [6:0]  fd_two;
    logic [27:0] acc10;
    n      = s;
    dig    = (c >= CH_ZERO) && (c <= CH_NINE);
    blank  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    d      = c[3:0];
    two    = 7'(s.accum[3:0]) * 7'd10 + 7'(d);
    fd_two = 7'(s.fd) * 7'd10 + 7'(d);
    acc10  = {4'd0, s.accum} * 28'd10 + {24'd0, d};
    if (!s.bad && (s.phase != PH_DONE)) begin
      case (s.phase)
        PH_BLANK: begin
          if (dig) begin
            n.fd    = d;
            n.phase = PH_YEAR2ND;
          end else if (c == CH_M) begin
            n.phase = PH_MJ;
          end else if (!blank) begin
            n.bad = 1'b1;
          end
        end
        PH_YEAR2ND: begin
          if (((s.fd == 4'd1) && (c == CH_NINE)) || ((s.fd == 4'd2) && dig)) begin
            n.cent  = fd_two[4:0];
            n.cnt   = 3'd2;
            n.phase = PH_YEARTAIL;
          end else if (dig && ((s.fd >= 4'd7) || (s.fd == 4'd0) ||
                               ((s.fd == 4'd1) && (d <= 4'd1)))) begin
            n.cent  = (s.fd >= 4'd7) ? CENT_19 : CENT_20;
            n.yoc   = fd_two;
            n.phase = PH_SEPMD;
          end else begin
            n.bad = 1'b1;
          end
        end
        PH_YEARTAIL: begin
          if (!dig) begin
            n.bad = 1'b1;
          end else if (s.cnt == 3'd2) begin
            n.yoc = 7'(d);
            n.cnt = 3'd3;
          end else begin
            n.yoc = 7'(s.yoc[3:0]) * 7'd10 + 7'(d);
            n.cnt = 3'd4;
            if ((s.cent == CENT_19) && (n.yoc < 7'd70)) begin
              n.bad = 1'b1;
            end else begin
              n.phase = PH_SEPMD;
            end
          end
        end
        PH_SEPMD: begin
          if (c == CH_NUL) begin
            n.is_date = 1'b1;
            n.stop    = idx;
            n.phase   = PH_DONE;
          end else if (dig) begin
            n.accum = 24'(d);
            n.phase = PH_MONTH2;
          end
        end
        PH_MONTH2: begin
          if (!dig) begin
            n.bad = 1'b1;
          end else begin
            n.mon   = two;
            n.phase = PH_SEPD;
          end
        end
        PH_SEPD: begin
          if (c == CH_NUL) begin
            n.bad = 1'b1;
          end else if (dig) begin
            n.accum = 24'(d);
            n.phase = PH_DAY2;
          end
        end
        PH_DAY2: begin
          if (!dig) begin
            n.bad = 1'b1;
          end else begin
            n.day     = two;
            n.is_date = 1'b1;
            n.phase   = PH_SEPH;
          end
        end
        PH_MJ: begin
          if (c == CH_J) begin
            n.phase = PH_MJD_D;
          end else begin
            n.bad = 1'b1;
          end
        end
        PH_MJD_D: begin
          if (c == CH_D) begin
            n.phase = PH_MJDSEP;
          end else begin
            n.bad = 1'b1;
          end
        end
        PH_MJDSEP: begin
          if (c == CH_NUL) begin
            n.bad = 1'b1;
          end else if (dig) begin
            n.accum = 24'(d);
            n.phase = PH_MJDDIG;
          end
        end
        PH_MJDDIG: begin
          if (dig) begin
            n.accum = acc10[23:0];
            if (acc10 > 28'(MJD_LIMIT)) begin
              n.bad = 1'b1;
            end
          end else begin
            n.dn = s.accum;
            if (s.accum < 24'(EPOCH_MJD)) begin
              n.bad = 1'b1;
            end else if (c == CH_NUL) begin
              n.stop  = idx;
              n.phase = PH_DONE;
            end else begin
              n.phase = PH_SEPH;
            end
          end
        end
        PH_SEPH: begin
          if (c == CH_NUL) begin
            n.stop  = idx;
            n.phase = PH_DONE;
          end else if (dig) begin
            n.accum = 24'(d);
            n.phase = PH_HOUR2;
          end
        end
        PH_HOUR2: begin
          n.hr = two;
          if (!dig || (two > 7'd23)) begin
            n.bad = 1'b1;
          end else begin
            n.phase = PH_SEPM;
          end
        end
        PH_SEPM: begin
          if (c == CH_NUL) begin
            n.stop  = idx;
            n.phase = PH_DONE;
          end else if (dig) begin
            n.accum = 24'(d);
            n.phase = PH_MIN2;
          end
        end
        PH_MIN2: begin
          n.mi = two;
          if (!dig || (two > 7'd59)) begin
            n.bad = 1'b1;
          end else begin
            n.phase = PH_SEPS;
          end
        end
        PH_SEPS: begin
          if (c == CH_NUL) begin
            n.stop  = idx;
            n.phase = PH_DONE;
          end else if (dig) begin
            n.accum = 24'(d);
            n.phase = PH_SEC2;
          end
        end
        PH_SEC2: begin
          n.se = two;
          if (!dig || (two > 7'd59)) begin
            n.bad = 1'b1;
          end else begin
            n.stop  = idx + IDXW'(1);
            n.phase = PH_DONE;
          end
        end
        default: begin
          n.bad = 1'b1;
        end
      endcase
    end
    return n;
  endfunction

  pst_t              st_q, st_d;
  logic [IDXW-1:0]   idx_q, idx_d;
  pst_t              s_take, s_a, s_end;
  logic [IDXW-1:0]   idx_a;
  logic [IDXW+6:0]   stop_wide;
  logic              acc;

  assign char_i.ready = rec_o.ready;
  assign rec_o.valid  = char_i.valid && char_i.data.last_char;
  assign acc          = char_i.valid && char_i.ready;

  always_comb begin
    s_take = take_char(st_q, char_i.data.char_code, idx_q);
    if (idx_q >= IDXW'(MAX_STRING_LEN)) begin
      s_a     = st_q;
      s_a.bad = 1'b1;
      idx_a   = idx_q;
    end else begin
      s_a   = s_take;
      idx_a = idx_q + IDXW'(1);
    end
    s_end     = take_char(s_a, CH_NUL, idx_a);
    stop_wide = {7'd0, s_end.stop};

    rec_o.data.bad     = s_end.bad || (s_end.phase != PH_DONE);
    rec_o.data.is_date = s_end.is_date;
    rec_o.data.cent    = s_end.cent;
    rec_o.data.yoc     = s_end.yoc;
    rec_o.data.mon     = s_end.mon;
    rec_o.data.day     = s_end.day;
    rec_o.data.dn      = s_end.dn;
    rec_o.data.hr      = s_end.hr;
    rec_o.data.mi      = s_end.mi;
    rec_o.data.se      = s_end.se;
    rec_o.data.stop    = stop_wide[6:0];

    st_d  = st_q;
    idx_d = idx_q;
    if (acc) begin
      if (char_i.data.last_char) begin
        st_d  = PST_RST;
        idx_d = '0;
      end else begin
        st_d  = s_a;
        idx_d = idx_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= PST_RST;
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_rearm_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && char_i.data.last_char) |=> (st_q.phase == PH_BLANK) && (idx_q == '0))
    else $error("parse state not rearmed after last beat");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !char_i.data.last_char) |=> (idx_q <= IDXW'(MAX_STRING_LEN)))
    else $error("character index past string limit");
`endif

endmodule
`default_nettype wire

FILE: sv/dsep_queue.sv
// Two-entry record queue between the parse front end and the calendar back end.
`default_nettype none
module dsep_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  dsep_stream_if.sink   in_s,
  dsep_stream_if.source out_s
);
  import dsep_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  rec_t              mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PW:0]       cnt_q, cnt_d;
  logic              push, pop;

  assign in_s.ready  = (cnt_q != (PW+1)'(DEPTH));
  assign out_s.valid = (cnt_q != '0);
  assign out_s.data  = mem_q[rd_ptr_q];
  assign push        = in_s.valid && in_s.ready;
  assign pop         = out_s.valid && out_s.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + (PW+1)'(1);
      2'b01:   cnt_d = cnt_q - (PW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_s.data;
    end
  end

endmodule
`default_nettype wire

FILE: sv/dsep_back.sv
// Calendar back end: date check, day count and seconds pipeline with output register.
`default_nettype none
module dsep_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  dsep_stream_if.sink   rec_i,
  dsep_stream_if.source res_o
);
  import dsep_pkg::*;

  typedef struct packed {
    logic        bad;
    logic        is_date;
    logic [11:0] yy;
    logic [3:0]  mon;
    logic [4:0]  day;
    logic [23:0] dn;
    logic [6:0]  hr;
    logic [6:0]  mi;
    logic [6:0]  se;
    logic [6:0]  stop;
  } b1_t;

  typedef struct packed {
    logic        bad;
    logic        is_date;
    logic [2:0]  era;
    logic [8:0]  yoe;
    logic [8:0]  doyp;
    logic [23:0] dn;
    logic [6:0]  hr;
    logic [6:0]  mi;
    logic [6:0]  se;
    logic [6:0]  stop;
  } b2_t;

  typedef struct packed {
    logic        bad;
    logic        is_date;
    logic [2:0]  era;
    logic [17:0] doe;
    logic [23:0] dn;
    logic [6:0]  hr;
    logic [6:0]  mi;
    logic [6:0]  se;
    logic [6:0]  stop;
  } b3_t;

  typedef struct packed {
    logic        bad;
    logic [23:0] days;
    logic [6:0]  hr;
    logic [6:0]  mi;
    logic [6:0]  se;
    logic [6:0]  stop;
  } b4_t;

  typedef struct packed {
    logic        bad;
    logic [40:0] part;
    logic [16:0] tod;
    logic [6:0]  stop;
  } b5_t;

  localparam int NSTG = 5;

  b1_t       b1_q, b1_d;
  b2_t       b2_q, b2_d;
  b3_t       b3_q, b3_d;
  b4_t       b4_q, b4_d;
  b5_t       b5_q, b5_d;
  res_beat_t out_q, out_d;
  logic [NSTG-1:0] vld_q;
  logic            out_vld_q;
  logic            en;

  logic        leap;
  logic [11:0] year;
  logic [4:0]  mlen;
  logic        date_ok;
  logic [1:0]  q100;
  logic [20:0] days_civil;

  assign en          = !out_vld_q || res_o.ready;
  assign rec_i.ready = en;
  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  always_comb begin
    // hold back the leap test until the century is known: xx00 needs the century digits
    leap    = (rec_i.data.yoc != 7'd0) ? (rec_i.data.yoc[1:0] == 2'd0)
                                       : (rec_i.data.cent[1:0] == 2'd0);
    year    = 12'(rec_i.data.cent) * 12'd100 + 12'(rec_i.data.yoc);
    mlen    = month_len(rec_i.data.mon[3:0], leap);
    date_ok = (rec_i.data.mon inside {[7'd1:7'd12]}) && (rec_i.data.day != 7'd0) &&
              (rec_i.data.day <= 7'(mlen));

    b1_d.bad     = rec_i.data.bad || (rec_i.data.is_date && !date_ok);
    b1_d.is_date = rec_i.data.is_date;
    b1_d.yy      = year - ((rec_i.data.mon <= 7'd2) ? 12'd1 : 12'd0);
    b1_d.mon     = rec_i.data.mon[3:0];
    b1_d.day     = rec_i.data.day[4:0];
    b1_d.dn      = rec_i.data.dn;
    b1_d.hr      = rec_i.data.hr;
    b1_d.mi      = rec_i.data.mi;
    b1_d.se      = rec_i.data.se;
    b1_d.stop    = rec_i.data.stop;

    b2_d.bad     = b1_q.bad;
    b2_d.is_date = b1_q.is_date;
    if (b1_q.yy >= 12'd2800) begin
      b2_d.era = 3'd7;
    end else if (b1_q.yy >= 12'd2400) begin
      b2_d.era = 3'd6;
    end else if (b1_q.yy >= 12'd2000) begin
      b2_d.era = 3'd5;
    end else begin
      b2_d.era = 3'd4;
    end
    b2_d.yoe  = 9'(b1_q.yy - 12'(b2_d.era) * 12'd400);
    b2_d.doyp = march_doy(b1_q.mon) + 9'(b1_q.day) - 9'd1;
    b2_d.dn   = b1_q.dn;
    b2_d.hr   = b1_q.hr;
    b2_d.mi   = b1_q.mi;
    b2_d.se   = b1_q.se;
    b2_d.stop = b1_q.stop;

    if (b2_q.yoe >= 9'd300) begin
      q100 = 2'd3;
    end else if (b2_q.yoe >= 9'd200) begin
      q100 = 2'd2;
    end else if (b2_q.yoe >= 9'd100) begin
      q100 = 2'd1;
    end else begin
      q100 = 2'd0;
    end
    b3_d.bad     = b2_q.bad;
    b3_d.is_date = b2_q.is_date;
    b3_d.era     = b2_q.era;
    b3_d.doe     = 18'(b2_q.yoe) * 18'd365 + 18'(b2_q.yoe[8:2]) - 18'(q100) +
                   18'(b2_q.doyp);
    b3_d.dn      = b2_q.dn;
    b3_d.hr      = b2_q.hr;
    b3_d.mi      = b2_q.mi;
    b3_d.se      = b2_q.se;
    b3_d.stop    = b2_q.stop;

    days_civil = 21'(b3_q.era) * 21'(DAYS_PER_ERA) + 21'(b3_q.doe) - 21'(CIVIL_TO_EPOCH);
    b4_d.bad   = b3_q.bad;
    b4_d.days  = b3_q.is_date ? 24'(days_civil) : (b3_q.dn - 24'(EPOCH_MJD));
    b4_d.hr    = b3_q.hr;
    b4_d.mi    = b3_q.mi;
    b4_d.se    = b3_q.se;
    b4_d.stop  = b3_q.stop;

    b5_d.bad  = b4_q.bad;
    b5_d.part = 41'(b4_q.days) * 41'(SEC_PER_DAY);
    b5_d.tod  = 17'(b4_q.hr) * 17'd3600 + 17'(b4_q.mi) * 17'd60 + 17'(b4_q.se);
    b5_d.stop = b4_q.stop;

    out_d.status        = b5_q.bad ? STATUS_BAD : STATUS_OK;
    out_d.epoch_seconds = b5_q.bad ? '0 : (b5_q.part + 41'(b5_q.tod));
    out_d.stop_index    = b5_q.bad ? '0 : b5_q.stop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NSTG-2:0], rec_i.valid};
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q  <= b1_d;
      b2_q  <= b2_d;
      b3_q  <= b3_d;
      b4_q  <= b4_d;
      b5_q  <= b5_d;
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_ok_has_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.data.status == STATUS_OK)) |-> (res_o.data.stop_index != '0))
    else $error("accepted date with zero stop index");

  a_ok_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.data.status == STATUS_OK)) |->
      (res_o.data.epoch_seconds <= EPOCH_MAX))
    else $error("epoch seconds beyond largest day number");

  a_pipe_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[NSTG-1]) |=> out_vld_q)
    else $error("pipeline beat lost before output register");
`endif

endmodule
`default_nettype wire
